### src/sgf_pkg.sv
// shared constants, config register struct and cosine table builder for the
// sine generator with fades; no dependencies
`timescale 1ns / 1ps

package sgf_pkg;

  // datapath sizing
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int TBL_N = 1 << TABLE_ADDR_BITS;

  // field widths
  localparam int CMD_W   = 2;
  localparam int FREQ_W  = 20;
  localparam int GAIN_W  = 15;
  localparam int FSTEP_W = 15;
  localparam int THR_W   = 16;
  localparam int PPH_W   = 32;
  localparam int FADE_W  = 16;
  localparam int MAG_W   = 15;
  localparam int OUT_W   = MAG_W + 1;

  localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(32768);

  // shared multiplier operand widths
  localparam int PROD1_W = SAMPLE_BITS - 1 + GAIN_W;
  localparam int MUL_A_W = (PROD1_W > FREQ_W) ? PROD1_W : FREQ_W;
  localparam int MUL_B_W = PPH_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // threshold compare width: cos * 2^15 against threshold * 2^(SAMPLE_BITS-1)
  localparam int CMP_W = SAMPLE_BITS + MAG_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREQ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SILENCE = 2'd2;

  // register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_GAIN      = 2'd0;
  localparam logic [1:0] REG_FADE_STEP = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_PHASE_HZ  = 2'd3;

  localparam logic [GAIN_W-1:0]         RST_GAIN      = GAIN_W'(16384);
  localparam logic [FSTEP_W-1:0]        RST_FADE_STEP = FSTEP_W'(64);
  localparam logic signed [THR_W-1:0]   RST_THRESHOLD = THR_W'(32000);
  localparam logic [PPH_W-1:0]          RST_PHASE_HZ  = PPH_W'(89478);

  // 440 Hz in 1/16 Hz units at the reset phase_per_hz
  localparam longint RST_FREQ_Q4 = 440 * 16;
  localparam logic [PHASE_BITS-1:0] RST_STEP =
    PHASE_BITS'((RST_FREQ_Q4 * longint'(RST_PHASE_HZ)) >>> 4);

  typedef struct packed {
    logic [GAIN_W-1:0]       gain;
    logic [FSTEP_W-1:0]      fade_step;
    logic signed [THR_W-1:0] switch_threshold;
    logic [PPH_W-1:0]        phase_per_hz;
  } cfg_t;

  // quarter-wave cosine table, built at elaboration
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TBL_N_L     = longint'(TBL_N);
  localparam longint AMP_MAX     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

  typedef logic [SAMPLE_BITS-2:0] quarter_t [0:TBL_N];

  function automatic quarter_t build_quarter();
    quarter_t tbl;
    longint   x;
    longint   x2;
    longint   r;
    for (int i = 0; i <= TBL_N; i++) begin
      x  = (longint'(i) * HALF_PI_Q30) / TBL_N_L;
      x2 = (x * x) / Q30_ONE;
      r  = Q30_ONE;
      // horner form of the taylor series, truncating divisions
      r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 182;
      r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 132;
      r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 90;
      r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 56;
      r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 30;
      r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 12;
      r  = Q30_ONE - ((x2 * r) / Q30_ONE) / 2;
      if (r < 0) begin
        r = 0;
      end
      if (r > Q30_ONE) begin
        r = Q30_ONE;
      end
      tbl[i] = (SAMPLE_BITS - 1)'((r * AMP_MAX + Q30_ONE / 2) / Q30_ONE);
    end
    return tbl;
  endfunction

endpackage

### src/sgf_cfg.sv
// apb register block: gain, fade step, switch threshold, phase per hz
// depends on sgf_pkg
`timescale 1ns / 1ps

module sgf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sgf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sgf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sgf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output sgf_pkg::cfg_t                   cfg_o
);
  import sgf_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_GAIN:      cfg_d.gain             = pwdata[GAIN_W-1:0];
        REG_FADE_STEP: cfg_d.fade_step        = pwdata[FSTEP_W-1:0];
        REG_THRESHOLD: cfg_d.switch_threshold = pwdata[THR_W-1:0];
        REG_PHASE_HZ:  cfg_d.phase_per_hz     = pwdata[PPH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN:      prdata = APB_DATA_W'(cfg_q.gain);
      REG_FADE_STEP: prdata = APB_DATA_W'(cfg_q.fade_step);
      REG_THRESHOLD: prdata = APB_DATA_W'(cfg_q.switch_threshold);
      REG_PHASE_HZ:  prdata = APB_DATA_W'(cfg_q.phase_per_hz);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain             <= RST_GAIN;
      cfg_q.fade_step        <= RST_FADE_STEP;
      cfg_q.switch_threshold <= RST_THRESHOLD;
      cfg_q.phase_per_hz     <= RST_PHASE_HZ;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/sgf_cos.sv
// cosine lookup: quadrant fold of the phase into a quarter-wave rom with
// registered read; depends on sgf_pkg (table builder)
`timescale 1ns / 1ps

module sgf_cos (
  input  logic                              clk_i,
  input  logic [sgf_pkg::PHASE_BITS-1:0]    phase_i,
  output logic [sgf_pkg::SAMPLE_BITS-2:0]   mag_o,
  output logic                              neg_o
);
  import sgf_pkg::*;

  localparam quarter_t QUARTER = build_quarter();
  localparam logic [TABLE_ADDR_BITS:0] TBL_END = (TABLE_ADDR_BITS + 1)'(TBL_N);

  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TABLE_ADDR_BITS:0]   rom_addr;
  logic [SAMPLE_BITS-2:0]     mag_q;
  logic                       neg_q;

  assign quad = phase_i[PHASE_BITS-1 -: 2];
  assign idx  = phase_i[PHASE_BITS-3 -: TABLE_ADDR_BITS];

  // odd quadrants run the table backwards
  assign rom_addr = quad[0] ? (TBL_END - {1'b0, idx}) : {1'b0, idx};

  always_ff @(posedge clk_i) begin
    mag_q <= QUARTER[rom_addr];
    neg_q <= quad[0] ^ quad[1];
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

### src/sgf_mul.sv
// shared unsigned multiplier with registered product and load enable
// depends on sgf_pkg
`timescale 1ns / 1ps

module sgf_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sgf_pkg::MUL_A_W-1:0]   a_i,
  input  logic [sgf_pkg::MUL_B_W-1:0]   b_i,
  output logic [sgf_pkg::MUL_P_W-1:0]   p_o
);
  import sgf_pkg::*;

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

### src/sine_generator_with_fades_top.sv
// sine generator with fades: sequencer, oscillator state and output register
// depends on sgf_pkg, sgf_cfg, sgf_cos, sgf_mul
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in      | sink      | in_valid_i / in_stall_o  | command_i, frequency_i
//   out     | source    | out_valid_o / out_stall_i| sample_o, is_silent_o, in_transition_o
//   cfg     | apb slave | psel, penable, pready  | paddr, pwdata, prdata
//
// a tick item stalls the input from acceptance until its output is written: evaluate,
// two passes through the shared multiplier, output; when a pending frequency takes
// over, the table is read again at phase 0 and a second evaluate follows, and a
// silent tick only evaluates and outputs. a frequency item stalls through one multiplier
// pass and the step update, a silence item does not stall. a stalled output holds a
// finished tick in its last cycle only. reset is immediate, the table is a rom.
`timescale 1ns / 1ps

module sine_generator_with_fades_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sgf_pkg::CMD_W-1:0]        command_i,
  input  logic [sgf_pkg::FREQ_W-1:0]       frequency_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [sgf_pkg::OUT_W-1:0] sample_o,
  output logic                             is_silent_o,
  output logic                             in_transition_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sgf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sgf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sgf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import sgf_pkg::*;

  typedef enum logic [2:0] {
    MODE_SILENT,
    MODE_STEADY,
    MODE_FADE_IN,
    MODE_FADE_OUT,
    MODE_SWITCH
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_MUL1,
    S_MUL2,
    S_DONE,
    S_STEP,
    S_STEP_SET
  } state_e;

  cfg_t cfg;

  state_e                  state_q, state_d;
  mode_e                   mode_q, mode_d;
  logic [PHASE_BITS-1:0]   phase_acc_q, phase_acc_d;
  logic [PHASE_BITS-1:0]   phase_step_q, phase_step_d;
  logic [PHASE_BITS-1:0]   pending_q, pending_d;
  logic [FADE_W-1:0]       fade_q, fade_d;
  logic [FREQ_W-1:0]       freq_q, freq_d;
  logic                    zero_q, zero_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] sample_q, sample_d;
  logic                    silent_q, silent_d;
  logic                    trans_q, trans_d;

  logic [SAMPLE_BITS-2:0]       cos_mag;
  logic                         cos_neg;
  logic signed [SAMPLE_BITS-1:0] cos_val;
  logic signed [CMP_W-1:0]      cos_wide;
  logic signed [CMP_W-1:0]      thr_wide;

  logic                 mul_en;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;

  logic [FADE_W:0]        fade_sum;
  logic [FADE_W-1:0]      fade_dec;
  logic [MAG_W-1:0]       scaled_mag;
  logic signed [OUT_W-1:0] scaled_pos;
  logic [PHASE_BITS-1:0]  new_step;

  sgf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sgf_cos u_cos (
    .clk_i   (clk_i),
    .phase_i (phase_acc_q),
    .mag_o   (cos_mag),
    .neg_o   (cos_neg)
  );

  sgf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign cos_val  = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  assign cos_wide = {cos_val, {MAG_W{1'b0}}};
  assign thr_wide = {cfg.switch_threshold, {(SAMPLE_BITS - 1){1'b0}}};

  assign fade_sum   = {1'b0, fade_q} + (FADE_W + 1)'(cfg.fade_step);
  assign fade_dec   = (fade_q > FADE_W'(cfg.fade_step)) ? fade_q - FADE_W'(cfg.fade_step) : '0;
  assign scaled_mag = mul_p[SAMPLE_BITS + 14 +: MAG_W];
  assign scaled_pos = $signed({1'b0, scaled_mag});
  assign new_step   = mul_p[PHASE_BITS + 3:4];

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign sample_o        = sample_q;
  assign is_silent_o     = silent_q;
  assign in_transition_o = trans_q;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    phase_acc_d  = phase_acc_q;
    phase_step_d = phase_step_q;
    pending_d    = pending_q;
    fade_d       = fade_q;
    freq_d       = freq_q;
    zero_d       = zero_q;
    out_valid_d  = out_valid_q;
    sample_d     = sample_q;
    silent_d     = silent_q;
    trans_d      = trans_q;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_TICK: state_d = S_EVAL;
            CMD_FREQ: begin
              freq_d  = frequency_i;
              state_d = S_STEP;
            end
            CMD_SILENCE: begin
              case (mode_q)
                MODE_FADE_IN, MODE_FADE_OUT: mode_d = MODE_FADE_OUT;
                MODE_STEADY, MODE_SWITCH: begin
                  pending_d = '0;
                  mode_d    = MODE_FADE_OUT;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end

      S_STEP: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(freq_q);
        mul_b   = cfg.phase_per_hz;
        state_d = S_STEP_SET;
      end

      S_STEP_SET: begin
        if (mode_q == MODE_SILENT) begin
          phase_step_d = new_step;
          pending_d    = '0;
          phase_acc_d  = '0;
          fade_d       = '0;
          mode_d       = MODE_FADE_IN;
        end else begin
          pending_d = new_step;
          fade_d    = FADE_ONE;
          mode_d    = MODE_SWITCH;
        end
        state_d = S_IDLE;
      end

      // table read after a takeover reset the phase
      S_LOOK: state_d = S_EVAL;

      S_EVAL: begin
        zero_d  = 1'b0;
        state_d = S_MUL1;
        case (mode_q)
          MODE_FADE_IN: begin
            if (fade_q < FADE_ONE) begin
              fade_d = (fade_sum > {1'b0, FADE_ONE}) ? FADE_ONE : fade_sum[FADE_W-1:0];
            end else begin
              mode_d = MODE_STEADY;
            end
          end
          MODE_FADE_OUT: begin
            if (fade_q != '0) begin
              fade_d = fade_dec;
            end else begin
              mode_d  = MODE_SILENT;
              zero_d  = 1'b1;
              state_d = S_DONE;
            end
          end
          MODE_SWITCH: begin
            if (cos_wide > thr_wide) begin
              mode_d       = MODE_STEADY;
              phase_step_d = pending_q;
              pending_d    = '0;
              phase_acc_d  = '0;
              fade_d       = FADE_ONE;
              state_d      = S_LOOK;
            end
          end
          MODE_STEADY: ;
          default: begin
            zero_d  = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end

      S_MUL1: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(cos_mag);
        mul_b   = MUL_B_W'(cfg.gain);
        state_d = S_MUL2;
      end

      // fade_q already holds the level of this tick
      S_MUL2: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(mul_p[PROD1_W-1:0]);
        mul_b   = MUL_B_W'(fade_q);
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (zero_q) begin
            sample_d = '0;
          end else begin
            sample_d = cos_neg ? -scaled_pos : scaled_pos;
          end
          silent_d    = (mode_q == MODE_SILENT);
          trans_d     = (mode_q == MODE_FADE_IN) || (mode_q == MODE_FADE_OUT) ||
                        (mode_q == MODE_SWITCH);
          phase_acc_d = phase_acc_q + phase_step_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_SILENT;
      phase_acc_q  <= '0;
      phase_step_q <= RST_STEP;
      pending_q    <= '0;
      fade_q       <= '0;
      freq_q       <= '0;
      zero_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      sample_q     <= '0;
      silent_q     <= 1'b0;
      trans_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      phase_acc_q  <= phase_acc_d;
      phase_step_q <= phase_step_d;
      pending_q    <= pending_d;
      fade_q       <= fade_d;
      freq_q       <= freq_d;
      zero_q       <= zero_d;
      out_valid_q  <= out_valid_d;
      sample_q     <= sample_d;
      silent_q     <= silent_d;
      trans_q      <= trans_d;
    end
  end

endmodule
